[hdl/smpl_pkg.sv]
// ----------------------------------------------------------------------------
// Sector map package
// Shared constants, function codes and the structs that pass between the
// storage, arithmetic and control parts of the sector map block.
// ----------------------------------------------------------------------------
package smpl_pkg;

    localparam int MAX_WALLS   = 1024;
    localparam int MAX_SECTORS = 256;
    localparam int WALL_AW     = $clog2(MAX_WALLS);
    localparam int SEC_AW      = $clog2(MAX_SECTORS);
    localparam int COUNT_W     = 11;
    localparam int TAG_W       = 2;

    localparam logic [2:0] FN_WR_WALL = 3'd0;
    localparam logic [2:0] FN_WR_SEC  = 3'd1;
    localparam logic [2:0] FN_INSIDE  = 3'd2;
    localparam logic [2:0] FN_LOCATE  = 3'd3;
    localparam logic [2:0] FN_COLLIDE = 3'd4;

    localparam logic signed [8:0] NO_SECTOR = -9'sd1;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [9:0]         link;
        logic signed [8:0]  portal;
    } t_wall;

    typedef struct packed {
        logic [9:0]         first_wall;
        logic [COUNT_W-1:0] walls;
    } t_sector;

    typedef struct packed {
        logic               wall_we;
        logic [WALL_AW-1:0] wall_waddr;
        t_wall              wall_wdata;
        logic               wall_re;
        logic [WALL_AW-1:0] wall_raddr;
        logic               sec_we;
        logic [SEC_AW-1:0]  sec_waddr;
        t_sector            sec_wdata;
        logic               sec_re;
        logic [SEC_AW-1:0]  sec_raddr;
    } t_mem_req;

    // One compare of (a1-a0)*(b1-b0) against (c1-c0)*(d1-d0).
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic signed [31:0] a1;
        logic signed [31:0] a0;
        logic signed [31:0] b1;
        logic signed [31:0] b0;
        logic signed [31:0] c1;
        logic signed [31:0] c0;
        logic signed [31:0] d1;
        logic signed [31:0] d0;
    } t_cmp_req;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic             lt;
        logic             gt;
    } t_cmp_rsp;

endpackage

[hdl/smpl_in_if.sv]
// ----------------------------------------------------------------------------
// Sector map request channel
// Valid/ready channel that carries one request beat.
// ----------------------------------------------------------------------------
interface smpl_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [9:0]         entry_index;
    logic signed [8:0]  hint_sector;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [9:0]         next_wall;
    logic signed [8:0]  neighbour_sector;
    logic [9:0]         start_wall;
    logic [10:0]        wall_count;

    modport source (
        output valid, func, entry_index, hint_sector, ax, ay, bx, by,
               next_wall, neighbour_sector, start_wall, wall_count,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, hint_sector, ax, ay, bx, by,
               next_wall, neighbour_sector, start_wall, wall_count,
        output ready
    );
endinterface

[hdl/smpl_out_if.sv]
// ----------------------------------------------------------------------------
// Sector map result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface smpl_out_if;
    logic              valid;
    logic              ready;
    logic              inside_res;
    logic signed [8:0] found_sector;
    logic              blocked;

    modport source (output valid, inside_res, found_sector, blocked, input ready);
    modport sink   (input  valid, inside_res, found_sector, blocked, output ready);
endinterface

[hdl/smpl_cfg_if.sv]
// ----------------------------------------------------------------------------
// Sector map configuration channel
// Valid/ready write channel for the sectors-in-use register.
// ----------------------------------------------------------------------------
interface smpl_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] sectors_in_use;

    modport source (output valid, sectors_in_use, input ready);
    modport sink   (input  valid, sectors_in_use, output ready);
endinterface

[hdl/smpl_store.sv]
// ----------------------------------------------------------------------------
// Sector map tables
// Wall and sector memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module smpl_store (
    input  logic               i_clk,
    input  smpl_pkg::t_mem_req i_req,
    output smpl_pkg::t_wall    o_wall_q,
    output smpl_pkg::t_sector  o_sec_q
);

    smpl_pkg::t_wall   r_wall_mem [smpl_pkg::MAX_WALLS];
    smpl_pkg::t_sector r_sec_mem  [smpl_pkg::MAX_SECTORS];

    always_ff @(posedge i_clk) begin
        if (i_req.wall_we) begin
            r_wall_mem[i_req.wall_waddr] <= i_req.wall_wdata;
        end
        if (i_req.wall_re) begin
            o_wall_q <= r_wall_mem[i_req.wall_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.sec_we) begin
            r_sec_mem[i_req.sec_waddr] <= i_req.sec_wdata;
        end
        if (i_req.sec_re) begin
            o_sec_q <= r_sec_mem[i_req.sec_raddr];
        end
    end

endmodule

[hdl/smpl_geom.sv]
// ----------------------------------------------------------------------------
// Sector map product comparator
// Three-stage pipeline: differences, two 33x33 products, exact compare.
// ----------------------------------------------------------------------------
module smpl_geom (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smpl_pkg::t_cmp_req i_req,
    output smpl_pkg::t_cmp_rsp o_rsp
);

    logic                         r_s1_valid;
    logic [smpl_pkg::TAG_W-1:0]   r_s1_tag;
    logic signed [32:0]           r_da, r_db, r_dc, r_dd;
    logic                         r_s2_valid;
    logic [smpl_pkg::TAG_W-1:0]   r_s2_tag;
    logic signed [65:0]           r_p1, r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            o_rsp.valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            o_rsp.valid <= r_s2_valid;
        end
        r_s1_tag <= i_req.tag;
        r_da <= 33'(i_req.a1) - 33'(i_req.a0);
        r_db <= 33'(i_req.b1) - 33'(i_req.b0);
        r_dc <= 33'(i_req.c1) - 33'(i_req.c0);
        r_dd <= 33'(i_req.d1) - 33'(i_req.d0);
        r_s2_tag <= r_s1_tag;
        r_p1 <= r_da * r_db;
        r_p2 <= r_dc * r_dd;
        o_rsp.tag <= r_s2_tag;
        o_rsp.lt  <= r_p1 < r_p2;
        o_rsp.gt  <= r_p1 > r_p2;
    end

endmodule

[hdl/smpl_ctrl.sv]
// ----------------------------------------------------------------------------
// Sector map sequencer
// Walks wall loops out of the tables, issues compares and runs the
// inside, locate and collide queries one at a time.
// ----------------------------------------------------------------------------
module smpl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [8:0]         i_sectors_in_use,
    smpl_in_if.sink            i_in,
    smpl_out_if.source         o_out,
    output smpl_pkg::t_mem_req o_mem,
    input  smpl_pkg::t_wall    i_wall_q,
    input  smpl_pkg::t_sector  i_sec_q,
    output smpl_pkg::t_cmp_req o_cmp,
    input  smpl_pkg::t_cmp_rsp i_cmp
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEC, S_SECD, S_W0D, S_WED, S_EDGE, S_ISS, S_GW, S_EVAL,
        S_ADV, S_RET, S_NB, S_NBD, S_SCAN, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        T_INSIDE, T_COLL, T_LHINT, T_LNB, T_SCAN
    } t_task;

    t_state                          r_state;
    t_task                           r_task;
    logic                            r_coll;
    logic signed [31:0]              r_x, r_y, r_bx, r_by;
    logic [smpl_pkg::SEC_AW-1:0]     r_hint;
    logic                            r_hint_ok;
    logic [smpl_pkg::SEC_AW-1:0]     r_sec;
    logic [smpl_pkg::COUNT_W-1:0]    r_n, r_i, r_on, r_oi;
    logic [smpl_pkg::WALL_AW-1:0]    r_ocur;
    logic [smpl_pkg::SEC_AW:0]       r_s;
    smpl_pkg::t_wall                 r_c, r_e;
    logic                            r_par, r_hit;
    logic [smpl_pkg::TAG_W-1:0]      r_op;
    logic [3:0]                      r_lt, r_gt;
    logic                            r_res_inside, r_res_blocked;
    logic signed [8:0]               r_res_found;

    logic accept;
    logic cross_cond;
    logic [smpl_pkg::TAG_W-1:0] last_tag;
    logic meet;

    // q lies within the bounding box of p and r.
    function automatic logic in_box(
        input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] qx, input logic signed [31:0] qy,
        input logic signed [31:0] rx, input logic signed [31:0] ry
    );
        logic ok_x, ok_y;
        ok_x = ((qx <= px) || (qx <= rx)) && ((qx >= px) || (qx >= rx));
        ok_y = ((qy <= py) || (qy <= ry)) && ((qy >= py) || (qy >= ry));
        return ok_x && ok_y;
    endfunction

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign cross_cond = (r_c.py > r_y) != (r_e.py > r_y);
    assign last_tag   = r_coll ? smpl_pkg::TAG_W'(3) : smpl_pkg::TAG_W'(0);

    // Segment test over the four orientations of the solid wall and the move.
    always_comb begin
        logic z0, z1, z2, z3;
        z0 = !r_lt[0] && !r_gt[0];
        z1 = !r_lt[1] && !r_gt[1];
        z2 = !r_lt[2] && !r_gt[2];
        z3 = !r_lt[3] && !r_gt[3];
        meet = (({r_gt[0], r_lt[0]} != {r_gt[1], r_lt[1]})
                && ({r_gt[2], r_lt[2]} != {r_gt[3], r_lt[3]}))
            || (z0 && in_box(r_c.px, r_c.py, r_x, r_y, r_e.px, r_e.py))
            || (z1 && in_box(r_c.px, r_c.py, r_bx, r_by, r_e.px, r_e.py))
            || (z2 && in_box(r_x, r_y, r_c.px, r_c.py, r_bx, r_by))
            || (z3 && in_box(r_x, r_y, r_e.px, r_e.py, r_bx, r_by));
    end

    // Memory requests.
    always_comb begin
        o_mem = '0;
        o_mem.wall_we    = accept && (i_in.func == smpl_pkg::FN_WR_WALL);
        o_mem.wall_waddr = i_in.entry_index;
        o_mem.wall_wdata.px     = i_in.ax;
        o_mem.wall_wdata.py     = i_in.ay;
        o_mem.wall_wdata.link   = i_in.next_wall;
        o_mem.wall_wdata.portal = i_in.neighbour_sector;
        o_mem.sec_we    = accept && (i_in.func == smpl_pkg::FN_WR_SEC)
                          && (i_in.entry_index < 10'(smpl_pkg::MAX_SECTORS));
        o_mem.sec_waddr = i_in.entry_index[smpl_pkg::SEC_AW-1:0];
        o_mem.sec_wdata.first_wall = i_in.start_wall;
        o_mem.sec_wdata.walls      = i_in.wall_count;
        o_mem.sec_re    = (r_state == S_SEC);
        o_mem.sec_raddr = r_sec;
        unique case (r_state)
            S_SECD: begin
                o_mem.wall_re    = (i_sec_q.walls != '0);
                o_mem.wall_raddr = i_sec_q.first_wall;
            end
            S_W0D: begin
                o_mem.wall_re    = 1'b1;
                o_mem.wall_raddr = i_wall_q.link;
            end
            S_ADV: begin
                o_mem.wall_re    = (smpl_pkg::COUNT_W'(r_i + 1'b1) != r_n);
                o_mem.wall_raddr = r_e.link;
            end
            S_NB: begin
                o_mem.wall_re    = (r_oi != r_on);
                o_mem.wall_raddr = r_ocur;
            end
            default: begin
                o_mem.wall_re    = 1'b0;
                o_mem.wall_raddr = r_ocur;
            end
        endcase
    end

    // Compare requests: the crossing test, or the four orientations.
    always_comb begin
        logic [smpl_pkg::TAG_W-1:0] op;
        op = (r_state == S_EDGE) ? '0 : r_op;
        o_cmp     = '0;
        o_cmp.tag = op;
        if (r_state == S_EDGE) begin
            o_cmp.valid = r_coll ? r_c.portal[8] : cross_cond;
        end else begin
            o_cmp.valid = (r_state == S_ISS);
        end
        if (!r_coll) begin
            o_cmp.a1 = r_x;    o_cmp.a0 = r_c.px;
            o_cmp.b1 = r_e.py; o_cmp.b0 = r_c.py;
            o_cmp.c1 = r_e.px; o_cmp.c0 = r_c.px;
            o_cmp.d1 = r_y;    o_cmp.d0 = r_c.py;
        end else begin
            case (op)
                2'd0: begin
                    o_cmp.a1 = r_e.py; o_cmp.a0 = r_c.py;
                    o_cmp.b1 = r_x;    o_cmp.b0 = r_e.px;
                    o_cmp.c1 = r_e.px; o_cmp.c0 = r_c.px;
                    o_cmp.d1 = r_y;    o_cmp.d0 = r_e.py;
                end
                2'd1: begin
                    o_cmp.a1 = r_e.py; o_cmp.a0 = r_c.py;
                    o_cmp.b1 = r_bx;   o_cmp.b0 = r_e.px;
                    o_cmp.c1 = r_e.px; o_cmp.c0 = r_c.px;
                    o_cmp.d1 = r_by;   o_cmp.d0 = r_e.py;
                end
                2'd2: begin
                    o_cmp.a1 = r_by;   o_cmp.a0 = r_y;
                    o_cmp.b1 = r_c.px; o_cmp.b0 = r_bx;
                    o_cmp.c1 = r_bx;   o_cmp.c0 = r_x;
                    o_cmp.d1 = r_c.py; o_cmp.d0 = r_by;
                end
                default: begin
                    o_cmp.a1 = r_by;   o_cmp.a0 = r_y;
                    o_cmp.b1 = r_e.px; o_cmp.b0 = r_bx;
                    o_cmp.c1 = r_bx;   o_cmp.c0 = r_x;
                    o_cmp.d1 = r_e.py; o_cmp.d0 = r_by;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out.valid <= 1'b0;
        end else begin
            // In S_OUT a taken beat is replaced by the new one below.
            if (o_out.valid && o_out.ready && (r_state != S_OUT)) begin
                o_out.valid <= 1'b0;
            end
            if (i_cmp.valid) begin
                r_lt[i_cmp.tag] <= i_cmp.lt;
                r_gt[i_cmp.tag] <= i_cmp.gt;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_x  <= i_in.ax;
                        r_y  <= i_in.ay;
                        r_bx <= i_in.bx;
                        r_by <= i_in.by;
                        r_sec <= i_in.entry_index[smpl_pkg::SEC_AW-1:0];
                        r_res_inside  <= 1'b0;
                        r_res_blocked <= 1'b0;
                        r_res_found   <= smpl_pkg::NO_SECTOR;
                        r_coll <= (i_in.func == smpl_pkg::FN_COLLIDE);
                        case (i_in.func)
                            smpl_pkg::FN_INSIDE, smpl_pkg::FN_COLLIDE: begin
                                r_task <= (i_in.func == smpl_pkg::FN_COLLIDE)
                                          ? T_COLL : T_INSIDE;
                                r_state <= (i_in.entry_index
                                            < 10'(smpl_pkg::MAX_SECTORS))
                                           ? S_SEC : S_OUT;
                            end
                            smpl_pkg::FN_LOCATE: begin
                                r_hint    <= i_in.hint_sector[smpl_pkg::SEC_AW-1:0];
                                r_hint_ok <= !i_in.hint_sector[8];
                                r_sec     <= i_in.hint_sector[smpl_pkg::SEC_AW-1:0];
                                r_s       <= '0;
                                r_task    <= T_LHINT;
                                r_state   <= i_in.hint_sector[8] ? S_SCAN : S_SEC;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SEC: r_state <= S_SECD;
                S_SECD: begin
                    r_n   <= i_sec_q.walls;
                    r_i   <= '0;
                    r_par <= 1'b0;
                    if (r_task == T_LHINT) begin
                        r_on   <= i_sec_q.walls;
                        r_oi   <= '0;
                        r_ocur <= i_sec_q.first_wall;
                    end
                    if (i_sec_q.walls == '0) begin
                        r_hit   <= 1'b0;
                        r_state <= S_RET;
                    end else begin
                        r_state <= S_W0D;
                    end
                end
                S_W0D: begin
                    r_c     <= i_wall_q;
                    r_state <= S_WED;
                end
                S_WED: begin
                    r_e     <= i_wall_q;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_op <= smpl_pkg::TAG_W'(1);
                    if (r_coll) begin
                        r_state <= r_c.portal[8] ? S_ISS : S_ADV;
                    end else begin
                        r_state <= cross_cond ? S_GW : S_ADV;
                    end
                end
                S_ISS: begin
                    r_op <= r_op + 1'b1;
                    if (r_op == last_tag) begin
                        r_state <= S_GW;
                    end
                end
                S_GW: begin
                    if (i_cmp.valid && (i_cmp.tag == last_tag)) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_coll) begin
                        if (meet) begin
                            r_hit   <= 1'b1;
                            r_state <= S_RET;
                        end else begin
                            r_state <= S_ADV;
                        end
                    end else begin
                        // The edge rises or falls through the query row.
                        if (((r_e.py > r_c.py) && r_lt[0])
                            || ((r_e.py < r_c.py) && r_gt[0])) begin
                            r_par <= !r_par;
                        end
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_i <= r_i + 1'b1;
                    r_c <= r_e;
                    if (smpl_pkg::COUNT_W'(r_i + 1'b1) == r_n) begin
                        r_hit   <= r_coll ? 1'b0 : r_par;
                        r_state <= S_RET;
                    end else begin
                        r_state <= S_WED;
                    end
                end
                S_RET: begin
                    unique case (r_task)
                        T_INSIDE: begin
                            r_res_inside <= r_hit;
                            r_state      <= S_OUT;
                        end
                        T_COLL: begin
                            r_res_blocked <= r_hit;
                            r_state       <= S_OUT;
                        end
                        T_LHINT, T_LNB: begin
                            if (r_hit) begin
                                r_res_found <= $signed({1'b0, r_sec});
                                r_state     <= S_OUT;
                            end else begin
                                r_state <= S_NB;
                            end
                        end
                        T_SCAN: begin
                            if (r_hit) begin
                                r_res_found <= $signed({1'b0, r_sec});
                                r_state     <= S_OUT;
                            end else begin
                                r_s     <= r_s + 1'b1;
                                r_state <= S_SCAN;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_NB: begin
                    r_state <= (r_oi == r_on) ? S_SCAN : S_NBD;
                end
                S_NBD: begin
                    r_ocur <= i_wall_q.link;
                    r_oi   <= r_oi + 1'b1;
                    if (!i_wall_q.portal[8]) begin
                        r_sec   <= i_wall_q.portal[smpl_pkg::SEC_AW-1:0];
                        r_task  <= T_LNB;
                        r_state <= S_SEC;
                    end else begin
                        r_state <= S_NB;
                    end
                end
                S_SCAN: begin
                    if (r_s[smpl_pkg::SEC_AW] || (r_s >= i_sectors_in_use)) begin
                        r_state <= S_OUT;
                    end else if (r_hint_ok && (r_s[smpl_pkg::SEC_AW-1:0] == r_hint)) begin
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_sec   <= r_s[smpl_pkg::SEC_AW-1:0];
                        r_task  <= T_SCAN;
                        r_state <= S_SEC;
                    end
                end
                S_OUT: begin
                    if (!o_out.valid || o_out.ready) begin
                        o_out.valid        <= 1'b1;
                        o_out.inside_res   <= r_res_inside;
                        o_out.found_sector <= r_res_found;
                        o_out.blocked      <= r_res_blocked;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/sector_map_point_locate_and_wall_collide.sv]
// A table write goes to memory on acceptance; a query is accepted, tests sectors,
// then outputs its result. Each sector tested reads its header, then walks its walls
// through the wall memory's single read port, sending edges that span the query row
// (or, in collide, solid walls) to the 3-stage product comparator. Locate tests the
// hint sector, its neighbours through portal walls, then a pass over sectors in use.
// Throughput: one item at a time. Reset clears control state and sectors in use.
// ----------------------------------------------------------------------------
// Sector map point locate and wall collide
// Wall/sector tables with inside, locate and collide queries.
// ----------------------------------------------------------------------------
module sector_map_point_locate_and_wall_collide (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smpl_in_if.sink    i_in,
    smpl_out_if.source o_out,
    smpl_cfg_if.sink   i_cfg
);

    logic [8:0]         r_sectors_in_use;
    smpl_pkg::t_mem_req mem_req;
    smpl_pkg::t_wall    wall_q;
    smpl_pkg::t_sector  sec_q;
    smpl_pkg::t_cmp_req cmp_req;
    smpl_pkg::t_cmp_rsp cmp_rsp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sectors_in_use <= '0;
        end else if (i_cfg.valid) begin
            r_sectors_in_use <= i_cfg.sectors_in_use;
        end
    end

    smpl_store u_store (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_wall_q (wall_q),
        .o_sec_q  (sec_q)
    );

    smpl_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cmp_req),
        .o_rsp   (cmp_rsp)
    );

    smpl_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sectors_in_use (r_sectors_in_use),
        .i_in             (i_in),
        .o_out            (o_out),
        .o_mem            (mem_req),
        .i_wall_q         (wall_q),
        .i_sec_q          (sec_q),
        .o_cmp            (cmp_req),
        .i_cmp            (cmp_rsp)
    );

endmodule
